// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker of the blink driver.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define IBR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define IBR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: hw/rtl/ibr_pkg.sv
// Package of the intensity to blink rate driver: payload types, lane control,
// sequencer states, register indexes and the divide-by-255 helper.
package ibr_pkg;

  localparam int NUM_LANES = 4;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [7:0] SLOW_PERIOD_RST = 8'd200;
  localparam logic [7:0] FAST_PERIOD_RST = 8'd20;
  localparam logic [6:0] MIN_ON_RST      = 7'd1;
  localparam logic [7:0] COUNT_MAX       = 8'd255;

  localparam logic [1:0] REG_SLOW_PERIOD = 2'd0;
  localparam logic [1:0] REG_FAST_PERIOD = 2'd1;
  localparam logic [1:0] REG_MIN_ON      = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] intensity_0;
    logic [7:0] intensity_1;
    logic [7:0] intensity_2;
    logic [7:0] intensity_3;
  } in_item_t;

  typedef struct packed {
    logic drive_0;
    logic drive_1;
    logic drive_2;
    logic drive_3;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic mul1;
    logic per;
    logic mul2;
    logic eval;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_PER,
    ST_MUL2,
    ST_EVAL
  } state_t;

  // Signed division by 255 truncating toward zero, for |x| below 65535.
  function automatic logic signed [9:0] div255(input logic signed [17:0] x);
    logic [15:0] mag;
    logic [16:0] sum;
    logic [8:0]  q;
    mag = x[17] ? 16'(-x) : 16'(x);
    sum = 17'(mag) + 17'(mag >> 8) + 17'd1;
    q   = sum[16:8];
    return x[17] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// File: hw/rtl/ibr_lane.sv
// One channel of the blink driver: intensity, phase and tick counter, with a
// shared multiplier and divide-by-255 stepped by the sequencer. Uses ibr_pkg.
module ibr_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ibr_pkg::lane_ctl_t   ctl,
  input  logic [7:0]           level_in,
  input  logic [7:0]           slow_period,
  input  logic [7:0]           fast_period,
  input  logic [6:0]           min_on,
  output logic                 drive_nxt
);

  logic [7:0]          level_r, level_nxt;
  logic                phase_r, phase_nxt;
  logic [7:0]          since_r, since_nxt;
  logic signed [17:0]  prod_r, prod_nxt;
  logic [7:0]          period_r, period_nxt;

  logic signed [8:0]   d1, d2, mul_b;
  logic signed [9:0]   q;
  logic signed [10:0]  per_raw, per_lo, per_c;
  logic signed [10:0]  on_raw;
  logic [7:0]          on_v, off_v, need;

  assign d1    = $signed({1'b0, slow_period}) - $signed({1'b0, fast_period});
  assign d2    = $signed({1'b0, period_r}) - $signed({1'b0, min_on, 1'b0});
  assign mul_b = ctl.mul1 ? d1 : d2;
  assign q     = ibr_pkg::div255(prod_r);

  always_comb begin
    per_raw = $signed({3'b000, slow_period}) - $signed({q[9], q});
    per_lo  = (per_raw < $signed({3'b000, fast_period})) ?
              $signed({3'b000, fast_period}) : per_raw;
    per_c   = (per_lo > $signed({3'b000, slow_period})) ?
              $signed({3'b000, slow_period}) : per_lo;
    on_raw  = $signed({4'b0000, min_on}) + $signed({q[9], q});
    if (on_raw[10]) begin
      on_v = 8'd0;
    end else if (on_raw > $signed({3'b000, period_r})) begin
      on_v = period_r;
    end else begin
      on_v = on_raw[7:0];
    end
    off_v = period_r - on_v;
    need  = phase_r ? on_v : off_v;
  end

  always_comb begin
    level_nxt  = ctl.load ? level_in : level_r;
    prod_nxt   = (ctl.mul1 || ctl.mul2) ? $signed({1'b0, level_r}) * mul_b : prod_r;
    period_nxt = ctl.per ? per_c[7:0] : period_r;
    phase_nxt  = phase_r;
    since_nxt  = since_r;
    if (ctl.tick && since_r != ibr_pkg::COUNT_MAX) begin
      since_nxt = since_r + 8'd1;
    end
    if (ctl.eval) begin
      if (level_r == 8'd0) begin
        phase_nxt = 1'b0;
        since_nxt = 8'd0;
      end else if (since_r >= need) begin
        phase_nxt = ~phase_r;
        since_nxt = 8'd0;
      end
    end
  end

  assign drive_nxt = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 8'd0;
      phase_r <= 1'b0;
      since_r <= 8'd0;
    end else begin
      level_r <= level_nxt;
      phase_r <= phase_nxt;
      since_r <= since_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    period_r <= period_nxt;
  end

endmodule

// File: hw/rtl/ibr_merge.sv
// Merging stage of the blink driver: gathers the lanes' drive bits into one
// result transaction and holds it in the output register. Uses ibr_pkg.
module ibr_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [ibr_pkg::NUM_LANES-1:0] drive,
  input  logic                         out_stall,
  output logic                         out_valid,
  output ibr_pkg::out_item_t           out_data,
  output logic                         out_free
);

  logic               valid_r, valid_nxt;
  ibr_pkg::out_item_t data_r, data_nxt;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt        = 1'b1;
      data_nxt.drive_0 = drive[0];
      data_nxt.drive_1 = drive[1];
      data_nxt.drive_2 = drive[2];
      data_nxt.drive_3 = drive[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hw/rtl/intensity_to_blink_rate_driver_unit.sv
// Top level of the four-channel intensity to blink rate driver: register
// port, sequencer, lanes and merging stage. Uses ibr_pkg, ibr_lane, ibr_merge.
//
// Each transaction goes from acceptance to the result register through
// the accepting cycle, then four steps that every lane runs in
// parallel on its own multiplier and divide-by-255 (period product, period
// clamp, on-time product, on-time clamp and phase update). in_stall stays high
// from acceptance until the result is loaded; if the result register is still
// held by out_stall, the last step waits for it. The next transaction can be
// accepted while a result waits to be taken. Configuration registers sit at
// byte addresses 0, 4 and 8 and are meant to be written only while idle.
module intensity_to_blink_rate_driver_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ibr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ibr_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ibr_pkg::ADDR_W-1:0]     paddr,
  input  logic [ibr_pkg::DATA_W-1:0]     pwdata,
  output logic [ibr_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  logic [7:0] slow_period_r, slow_period_nxt;
  logic [7:0] fast_period_r, fast_period_nxt;
  logic [6:0] min_on_r, min_on_nxt;

  ibr_pkg::state_t   state_r, state_nxt;
  ibr_pkg::lane_ctl_t ctl;
  logic              accept;
  logic              out_free;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic [7:0]        lvl [ibr_pkg::NUM_LANES];
  logic [ibr_pkg::NUM_LANES-1:0] drive;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    slow_period_nxt = slow_period_r;
    fast_period_nxt = fast_period_r;
    min_on_nxt      = min_on_r;
    prdata          = '0;
    unique case (reg_idx)
      ibr_pkg::REG_SLOW_PERIOD: begin
        prdata = 32'(slow_period_r);
        if (cfg_wr) slow_period_nxt = pwdata[7:0];
      end
      ibr_pkg::REG_FAST_PERIOD: begin
        prdata = 32'(fast_period_r);
        if (cfg_wr) fast_period_nxt = pwdata[7:0];
      end
      ibr_pkg::REG_MIN_ON: begin
        prdata = 32'(min_on_r);
        if (cfg_wr) min_on_nxt = pwdata[6:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_period_r <= ibr_pkg::SLOW_PERIOD_RST;
      fast_period_r <= ibr_pkg::FAST_PERIOD_RST;
      min_on_r      <= ibr_pkg::MIN_ON_RST;
    end else begin
      slow_period_r <= slow_period_nxt;
      fast_period_r <= fast_period_nxt;
      min_on_r      <= min_on_nxt;
    end
  end

  assign in_stall = (state_r != ibr_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ibr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ibr_pkg::ST_IDLE: begin
        ctl.load = accept && in_data.opcode;
        ctl.tick = accept && !in_data.opcode;
        if (accept) state_nxt = ibr_pkg::ST_MUL1;
      end
      ibr_pkg::ST_MUL1: begin
        ctl.mul1  = 1'b1;
        state_nxt = ibr_pkg::ST_PER;
      end
      ibr_pkg::ST_PER: begin
        ctl.per   = 1'b1;
        state_nxt = ibr_pkg::ST_MUL2;
      end
      ibr_pkg::ST_MUL2: begin
        ctl.mul2  = 1'b1;
        state_nxt = ibr_pkg::ST_EVAL;
      end
      ibr_pkg::ST_EVAL: begin
        ctl.eval = out_free;
        if (out_free) state_nxt = ibr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ibr_pkg::ST_IDLE;
      end
    endcase
  end

  assign lvl[0] = in_data.intensity_0;
  assign lvl[1] = in_data.intensity_1;
  assign lvl[2] = in_data.intensity_2;
  assign lvl[3] = in_data.intensity_3;

  for (genvar i = 0; i < ibr_pkg::NUM_LANES; i++) begin : g_lane
    ibr_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .level_in    (lvl[i]),
      .slow_period (slow_period_r),
      .fast_period (fast_period_r),
      .min_on      (min_on_r),
      .drive_nxt   (drive[i])
    );
  end

  ibr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.eval),
    .drive     (drive),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_free  (out_free)
  );

endmodule

// File: hw/rtl/ibr_checker.sv
// Port-level checker for the blink driver, bound to the top level.
// Uses ibr_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module ibr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ibr_pkg::out_item_t out_data
);

  `IBR_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
  `IBR_ASSERT(a_result_from_work, clk, rst_n, $rose(out_valid) |-> $past(in_stall))
  `IBR_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
  `IBR_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)

endmodule

bind intensity_to_blink_rate_driver_unit ibr_checker u_ibr_checker (.*);
